>>> hw/rtl/tlpq_pkg.sv
// Shared types and constants for the three-level priority queue.
`timescale 1ns / 1ps
`default_nettype none

package tlpq_pkg;

   localparam int Capacity = 16;
   localparam int IdxW     = $clog2(Capacity);
   localparam int CntW     = $clog2(Capacity + 1);
   localparam int IdW      = 16;
   localparam int ClsW     = 2;
   localparam int OccW     = 5;

   localparam logic [ClsW-1:0] ClassLowest = 2'd2;

   localparam logic KindInsert = 1'b0;
   localparam logic KindPop    = 1'b1;

   localparam logic [1:0] StatInserted = 2'd0;
   localparam logic [1:0] StatPopped   = 2'd1;
   localparam logic [1:0] StatEmpty    = 2'd2;
   localparam logic [1:0] StatFull     = 2'd3;

   typedef struct packed {
      logic [ClsW-1:0] cls;
      logic [IdW-1:0]  id;
   } entry_type;

endpackage

`default_nettype wire

>>> hw/rtl/three_level_priority_queue.sv
// Top level of the three-level priority queue: sequencer over a ring-ordered store.
//
// Command port: a word (req_kind, req_vehicle_id, req_priority_class) is taken
// at a clock edge where start is high and busy is low. Kind insert places the
// id behind every stored entry of equal or better class (class 3 counts as 2);
// kind pop removes the head entry. Each command yields exactly one response
// word on the rsp_ ports, marked by rsp_strobe for a single cycle; the
// receiver cannot hold it off, so it must take it in that cycle.
// Entries sit sorted in a ring inside one memory; a pop only advances the
// head pointer. An insert walks from the tail toward the head, one entry per
// cycle, moving each entry of worse class up by one slot.
// A pop on an empty store, or an insert into a full or empty store, is answered
// straight from idle; a pop reads the head entry first, and an insert into a
// non-empty store walks as above. One entry moves per cycle on the single
// memory write port. One command at a time: no new one is taken while busy.
// busy is high from the cycle after a command that leaves idle is taken until the
// response strobe; a new command may be given in the strobe cycle.
// Reset (synchronous, active high) empties the queue at once; no clearing
// pass is needed since only stored entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module three_level_priority_queue (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output      logic                         busy,
   input  wire logic                         req_kind,
   input  wire logic [tlpq_pkg::IdW-1:0]     req_vehicle_id,
   input  wire logic [tlpq_pkg::ClsW-1:0]    req_priority_class,
   output      logic                         rsp_strobe,
   output      logic [1:0]                   rsp_status,
   output      logic [tlpq_pkg::IdW-1:0]     rsp_popped_id,
   output      logic [tlpq_pkg::ClsW-1:0]    rsp_popped_class,
   output      logic [tlpq_pkg::OccW-1:0]    rsp_occupancy
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_POP_OUT
   } state_type;

   localparam int CntW = tlpq_pkg::CntW;
   localparam int IdxW = tlpq_pkg::IdxW;

   state_type                     state_ff, state_in;
   logic [CntW-1:0]               count_ff, count_in;
   logic [IdxW-1:0]               head_ff, head_in;
   logic [CntW-1:0]               pos_ff, pos_in;
   tlpq_pkg::entry_type           new_ff, new_in;
   logic                          rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]                    rsp_status_ff, rsp_status_in;
   logic [tlpq_pkg::IdW-1:0]      rsp_id_ff, rsp_id_in;
   logic [tlpq_pkg::ClsW-1:0]     rsp_cls_ff, rsp_cls_in;
   logic [tlpq_pkg::OccW-1:0]     rsp_occ_ff, rsp_occ_in;

   logic                          wr_en;
   logic [IdxW-1:0]               wr_addr;
   tlpq_pkg::entry_type           wr_data;
   logic [IdxW-1:0]               rd_addr;
   tlpq_pkg::entry_type           rd_data;
   tlpq_pkg::entry_type           req_entry;

   // logical slot -> memory address, ring starting at head
   function automatic logic [IdxW-1:0] phys(input logic [IdxW-1:0] head,
                                            input logic [CntW-1:0] slot);
      logic [CntW:0] s;
      s = (CntW+1)'(head) + (CntW+1)'(slot);
      if (s >= (CntW+1)'(tlpq_pkg::Capacity)) begin
         s = s - (CntW+1)'(tlpq_pkg::Capacity);
      end
      return s[IdxW-1:0];
   endfunction

   tlpq_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      req_entry.id  = req_vehicle_id;
      req_entry.cls = (req_priority_class > tlpq_pkg::ClassLowest) ?
                      tlpq_pkg::ClassLowest : req_priority_class;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      pos_in        = pos_ff;
      new_in        = new_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_cls_in    = rsp_cls_ff;
      wr_en         = 1'b0;
      wr_addr       = phys(head_ff, pos_ff);
      wr_data       = new_ff;
      // look-ahead read of the next slot toward the head
      rd_addr       = phys(head_ff, pos_ff - CntW'(2));

      case (state_ff)
         ST_IDLE: begin
            rd_addr = (req_kind == tlpq_pkg::KindPop) ? head_ff :
                      phys(head_ff, count_ff - CntW'(1));
            if (start) begin
               if (req_kind == tlpq_pkg::KindInsert) begin
                  if (count_ff == CntW'(tlpq_pkg::Capacity)) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = tlpq_pkg::StatFull;
                     rsp_id_in     = '0;
                     rsp_cls_in    = '0;
                  end else if (count_ff == '0) begin
                     wr_en         = 1'b1;
                     wr_addr       = head_ff;
                     wr_data       = req_entry;
                     count_in      = count_ff + CntW'(1);
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = tlpq_pkg::StatInserted;
                     rsp_id_in     = '0;
                     rsp_cls_in    = '0;
                  end else begin
                     new_in   = req_entry;
                     pos_in   = count_ff;
                     state_in = ST_INS_CMP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = tlpq_pkg::StatEmpty;
                     rsp_id_in     = '0;
                     rsp_cls_in    = '0;
                  end else begin
                     state_in = ST_POP_OUT;
                  end
               end
            end
         end
         ST_INS_CMP: begin
            wr_en = 1'b1;
            if (rd_data.cls > new_ff.cls) begin
               // worse class: move it up one slot
               wr_data = rd_data;
               pos_in  = pos_ff - CntW'(1);
               if (pos_ff == CntW'(1)) begin
                  state_in = ST_INS_PUT;
               end
            end else begin
               count_in      = count_ff + CntW'(1);
               rsp_strobe_in = 1'b1;
               rsp_status_in = tlpq_pkg::StatInserted;
               rsp_id_in     = '0;
               rsp_cls_in    = '0;
               state_in      = ST_IDLE;
            end
         end
         ST_INS_PUT: begin
            wr_en         = 1'b1;
            count_in      = count_ff + CntW'(1);
            rsp_strobe_in = 1'b1;
            rsp_status_in = tlpq_pkg::StatInserted;
            rsp_id_in     = '0;
            rsp_cls_in    = '0;
            state_in      = ST_IDLE;
         end
         ST_POP_OUT: begin
            head_in       = (head_ff == IdxW'(tlpq_pkg::Capacity - 1)) ? '0 :
                            head_ff + IdxW'(1);
            count_in      = count_ff - CntW'(1);
            rsp_strobe_in = 1'b1;
            rsp_status_in = tlpq_pkg::StatPopped;
            rsp_id_in     = rd_data.id;
            rsp_cls_in    = rd_data.cls;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_occ_in = tlpq_pkg::OccW'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         head_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         head_ff       <= head_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      pos_ff        <= pos_in;
      new_ff        <= new_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_cls_ff    <= rsp_cls_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_popped_id    = rsp_id_ff;
   assign rsp_popped_class = rsp_cls_ff;
   assign rsp_occupancy    = rsp_occ_ff;

endmodule

`default_nettype wire

>>> hw/rtl/tlpq_store.sv
// Entry memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tlpq_store (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [tlpq_pkg::IdxW-1:0]   wr_addr,
   input  wire tlpq_pkg::entry_type         wr_data,
   input  wire logic [tlpq_pkg::IdxW-1:0]   rd_addr,
   output tlpq_pkg::entry_type              rd_data
);

   tlpq_pkg::entry_type mem_ff [tlpq_pkg::Capacity];
   tlpq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
